FILE: sv/kow_pkg.sv
`default_nettype none
package kow_pkg;

    typedef logic [3:0] t_perm [16];

    // Global key registers, handed to the decode logic as one group
    typedef struct packed {
        logic [7:0] one;
        logic [7:0] two;
        logic [7:0] three;
    } t_gkeys;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_GKEY_ONE   = 2'd0,
        REG_GKEY_TWO   = 2'd1,
        REG_GKEY_THREE = 2'd2,
        REG_UNUSED     = 2'd3
    } t_reg_idx;

    localparam logic [15:0] ROUND1_XOR = 16'h6561;
    localparam logic [15:0] ROUND2_XOR = 16'h3523;
    localparam logic [15:0] ROUND3_XOR = 16'h99a5;
    localparam logic [15:0] FINAL_XOR  = 16'h87ff;
    localparam logic [15:0] MASKED     = 16'hffff;

    // Entry k of each table names the source bit for output bit 15-k
    localparam t_perm PM_R1A = '{4'd15, 4'd14, 4'd13, 4'd9, 4'd11, 4'd10, 4'd12, 4'd8,
                                 4'd2, 4'd6, 4'd5, 4'd4, 4'd3, 4'd7, 4'd1, 4'd0};
    localparam t_perm PM_R1B = '{4'd15, 4'd9, 4'd10, 4'd13, 4'd3, 4'd12, 4'd0, 4'd14,
                                 4'd6, 4'd5, 4'd2, 4'd11, 4'd8, 4'd1, 4'd4, 4'd7};
    localparam t_perm PM_R2A = '{4'd15, 4'd14, 4'd10, 4'd12, 4'd11, 4'd13, 4'd9, 4'd4,
                                 4'd7, 4'd6, 4'd5, 4'd8, 4'd3, 4'd2, 4'd1, 4'd0};
    localparam t_perm PM_R2B = '{4'd13, 4'd14, 4'd7, 4'd0, 4'd8, 4'd6, 4'd4, 4'd2,
                                 4'd1, 4'd15, 4'd3, 4'd11, 4'd12, 4'd10, 4'd5, 4'd9};
    localparam t_perm PM_R3A = '{4'd0, 4'd14, 4'd13, 4'd12, 4'd15, 4'd10, 4'd9, 4'd8,
                                 4'd7, 4'd6, 4'd11, 4'd4, 4'd3, 4'd2, 4'd1, 4'd5};
    localparam t_perm PM_R3B = '{4'd10, 4'd2, 4'd13, 4'd7, 4'd8, 4'd0, 4'd3, 4'd14,
                                 4'd6, 4'd15, 4'd1, 4'd11, 4'd9, 4'd4, 4'd5, 4'd12};
    localparam t_perm PM_FIN = '{4'd5, 4'd15, 4'd13, 4'd14, 4'd6, 4'd0, 4'd9, 4'd10,
                                 4'd4, 4'd11, 4'd1, 4'd2, 4'd12, 4'd3, 4'd7, 4'd8};
    localparam t_perm PM_S4  = '{4'd6, 4'd14, 4'd13, 4'd12, 4'd11, 4'd10, 4'd9, 4'd5,
                                 4'd7, 4'd15, 4'd8, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0};
    localparam t_perm PM_S3  = '{4'd15, 4'd12, 4'd14, 4'd13, 4'd11, 4'd10, 4'd9, 4'd8,
                                 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0};
    localparam t_perm PM_S2  = '{4'd15, 4'd14, 4'd13, 4'd12, 4'd11, 4'd2, 4'd9, 4'd8,
                                 4'd10, 4'd6, 4'd5, 4'd4, 4'd3, 4'd0, 4'd1, 4'd7};
    localparam t_perm PM_K3  = '{4'd15, 4'd14, 4'd13, 4'd12, 4'd11, 4'd10, 4'd4, 4'd8,
                                 4'd7, 4'd6, 4'd5, 4'd9, 4'd1, 4'd2, 4'd3, 4'd0};
    localparam t_perm PM_K2  = '{4'd15, 4'd12, 4'd13, 4'd14, 4'd11, 4'd10, 4'd9, 4'd8,
                                 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0};
    localparam t_perm PM_S1  = '{4'd15, 4'd14, 4'd13, 4'd12, 4'd9, 4'd8, 4'd11, 4'd10,
                                 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0};
    localparam t_perm PM_K5  = '{4'd15, 4'd14, 4'd13, 4'd12, 4'd11, 4'd10, 4'd9, 4'd8,
                                 4'd4, 4'd5, 4'd7, 4'd6, 4'd3, 4'd2, 4'd1, 4'd0};
    localparam t_perm PM_S0  = '{4'd15, 4'd14, 4'd13, 4'd12, 4'd11, 4'd10, 4'd9, 4'd8,
                                 4'd7, 4'd6, 4'd5, 4'd4, 4'd0, 4'd3, 4'd2, 4'd1};
    localparam t_perm PM_LOW = '{4'd12, 4'd15, 4'd14, 4'd13, 4'd11, 4'd10, 4'd9, 4'd8,
                                 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0};

    // Route bits of a word through a fixed table
    function automatic logic [15:0] perm(input logic [15:0] v, input t_perm src);
        logic [15:0] r;
        r = '0;
        for (int k = 0; k < 16; k++) begin
            r[15-k] = v[src[k]];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: sv/kow_rounds.sv
`default_nettype none
module kow_rounds
    import kow_pkg::*;
(
    input  wire logic [15:0] i_word,
    input  wire logic [7:0]  i_main_key,
    input  wire t_gkeys      i_gkeys,
    output logic      [15:0] o_word
);

    logic [7:0]  g1, g2, g3, mk;
    logic        gx0, gx1, gs0a, gs0b, gs1, gs2, gs3, gs4;
    logic        k0a, k0b, k0c, k1a, k1b, k2a, k2b, k3a, k3b;
    logic        k4a, k4b, k5a, k5b, k6a, k6b, k7a;
    logic [15:0] v;

    assign g1 = i_gkeys.one;
    assign g2 = i_gkeys.two;
    assign g3 = i_gkeys.three;
    assign mk = i_main_key;

    // Form switch bits from the main key and the global keys
    assign gx0  = ~g1[5];
    assign gx1  = ~g1[2];
    assign gs2  = ~g1[0];
    assign gs0a = ~g2[5];
    assign gs0b = ~g2[2];
    assign gs3  = ~g3[6];
    assign gs1  = ~g3[4];
    assign gs4  = ~g3[2];
    assign k0a  = mk[0] ^ g3[1];
    assign k0b  = mk[0] ^ g1[7];
    assign k0c  = mk[0] ^ g1[1];
    assign k1a  = mk[1] ^ g2[7];
    assign k1b  = mk[1] ^ g1[3];
    assign k2a  = mk[2] ^ g3[7];
    assign k2b  = mk[2] ^ g1[4];
    assign k3a  = mk[3] ^ g2[0];
    assign k3b  = mk[3] ^ g3[3];
    assign k4a  = mk[4] ^ g2[3];
    assign k4b  = mk[4] ^ g3[0];
    assign k5a  = mk[5] ^ g3[5];
    assign k5b  = mk[5] ^ g1[6];
    assign k6a  = mk[6] ^ g2[1];
    assign k6b  = mk[6] ^ g2[6];
    assign k7a  = mk[7] ^ g2[4];

    // Keyed rounds, fixed stage, swaps; top bits 000: PM_LOW
    always_comb begin
        v = i_word;
        if (i_word[15:13] == 3'b000) begin
            v = perm(i_word, PM_LOW);
        end else begin
            if (v[15]) begin
                if (!gx1 && !v[3])  v = v ^ 16'h2410;
                if (!v[2])          v = v ^ 16'h0022;
                if (!k1b && !v[12]) v = v ^ 16'h0848;
                if (!gs2 && !k0c)   v = v ^ 16'h4101;
                if (!k2b)           v = perm(v, PM_R1A);
                v = ROUND1_XOR ^ perm(v, PM_R1B);
            end
            if (v[14]) begin
                if (!gx0 && v[11]) v = v ^ 16'h9048;
                if (!k3a && v[2])  v = v ^ 16'h0202;
                if (!k6a && v[10]) v = v ^ 16'h0004;
                if (!k5b && !k0b)  v = v ^ 16'h08a1;
                if (!gs0b)         v = perm(v, PM_R2A);
                v = ROUND2_XOR ^ perm(v, PM_R2B);
            end
            if (v[13]) begin
                if (!k4a && v[8]) v = v ^ 16'h4210;
                if (!k1a && v[6]) v = v ^ 16'h0080;
                if (!k7a && v[0]) v = v ^ 16'h110a;
                if (!k4b && !k0a) v = v ^ 16'h0040;
                if (!gs0a && !k6b) v = v ^ 16'h0404;
                if (!k5b)         v = perm(v, PM_R3A);
                v = ROUND3_XOR ^ perm(v, PM_R3B);
            end
            v = FINAL_XOR ^ perm(v, PM_FIN);
            if (!gs4)  v = perm(v, PM_S4);
            if (!gs3)  v = perm(v, PM_S3);
            if (!gs2)  v = perm(v, PM_S2);
            if (!k3b)  v = perm(v, PM_K3);
            if (!k2a)  v = perm(v, PM_K2);
            if (!gs1)  v = perm(v, PM_S1);
            if (!k5a)  v = perm(v, PM_K5);
            if (!gs0a) v = perm(v, PM_S0);
        end
    end

    assign o_word = v;

endmodule
`default_nettype wire

FILE: sv/kow_mask.sv
`default_nettype none
module kow_mask
    import kow_pkg::*;
(
    input  wire logic [15:0] i_word,
    input  wire logic        i_extra_mask_mode,
    output logic      [15:0] o_word
);

    // Match PC-relative opcodes, bit 0 ignored
    function automatic logic is_pcrel(input logic [15:0] d);
        logic hit;
        hit = 1'b0;
        unique case ({d[15:1], 1'b0})
            16'h013a, 16'h033a, 16'h053a, 16'h073a, 16'h083a, 16'h093a, 16'h0b3a,
            16'h0d3a, 16'h0f3a,
            16'h103a, 16'h10ba, 16'h10fa, 16'h113a, 16'h117a, 16'h11ba, 16'h11fa,
            16'h123a, 16'h12ba, 16'h12fa, 16'h133a, 16'h137a, 16'h13ba, 16'h13fa,
            16'h143a, 16'h14ba, 16'h14fa, 16'h153a, 16'h157a, 16'h15ba,
            16'h163a, 16'h16ba, 16'h16fa, 16'h173a, 16'h177a, 16'h17ba,
            16'h183a, 16'h18ba, 16'h18fa, 16'h193a, 16'h197a, 16'h19ba,
            16'h1a3a, 16'h1aba, 16'h1afa, 16'h1b3a, 16'h1b7a, 16'h1bba,
            16'h1c3a, 16'h1cba, 16'h1cfa, 16'h1d3a, 16'h1d7a, 16'h1dba,
            16'h1e3a, 16'h1eba, 16'h1efa, 16'h1f3a, 16'h1f7a, 16'h1fba,
            16'h203a, 16'h207a, 16'h20ba, 16'h20fa, 16'h213a, 16'h217a, 16'h21ba,
            16'h21fa,
            16'h223a, 16'h227a, 16'h22ba, 16'h22fa, 16'h233a, 16'h237a, 16'h23ba,
            16'h23fa,
            16'h243a, 16'h247a, 16'h24ba, 16'h24fa, 16'h253a, 16'h257a, 16'h25ba,
            16'h263a, 16'h267a, 16'h26ba, 16'h26fa, 16'h273a, 16'h277a, 16'h27ba,
            16'h283a, 16'h287a, 16'h28ba, 16'h28fa, 16'h293a, 16'h297a, 16'h29ba,
            16'h2a3a, 16'h2a7a, 16'h2aba, 16'h2afa, 16'h2b3a, 16'h2b7a, 16'h2bba,
            16'h2c3a, 16'h2c7a, 16'h2cba, 16'h2cfa, 16'h2d3a, 16'h2d7a, 16'h2dba,
            16'h2e3a, 16'h2e7a, 16'h2eba, 16'h2efa, 16'h2f3a, 16'h2f7a, 16'h2fba,
            16'h303a, 16'h307a, 16'h30ba, 16'h30fa, 16'h313a, 16'h317a, 16'h31ba,
            16'h31fa,
            16'h323a, 16'h327a, 16'h32ba, 16'h32fa, 16'h333a, 16'h337a, 16'h33ba,
            16'h33fa,
            16'h343a, 16'h347a, 16'h34ba, 16'h34fa, 16'h353a, 16'h357a, 16'h35ba,
            16'h363a, 16'h367a, 16'h36ba, 16'h36fa, 16'h373a, 16'h377a, 16'h37ba,
            16'h383a, 16'h387a, 16'h38ba, 16'h38fa, 16'h393a, 16'h397a, 16'h39ba,
            16'h3a3a, 16'h3a7a, 16'h3aba, 16'h3afa, 16'h3b3a, 16'h3b7a, 16'h3bba,
            16'h3c3a, 16'h3c7a, 16'h3cba, 16'h3cfa, 16'h3d3a, 16'h3d7a, 16'h3dba,
            16'h3e3a, 16'h3e7a, 16'h3eba, 16'h3efa, 16'h3f3a, 16'h3f7a, 16'h3fba,
            16'h41ba, 16'h43ba, 16'h44fa, 16'h45ba, 16'h46fa, 16'h47ba, 16'h49ba,
            16'h4bba, 16'h4cba, 16'h4cfa, 16'h4dba, 16'h4fba,
            16'h803a, 16'h807a, 16'h80ba, 16'h80fa, 16'h81fa, 16'h823a, 16'h827a,
            16'h82ba, 16'h82fa, 16'h83fa,
            16'h843a, 16'h847a, 16'h84ba, 16'h84fa, 16'h85fa, 16'h863a, 16'h867a,
            16'h86ba, 16'h86fa, 16'h87fa,
            16'h883a, 16'h887a, 16'h88ba, 16'h88fa, 16'h89fa, 16'h8a3a, 16'h8a7a,
            16'h8aba, 16'h8afa, 16'h8bfa,
            16'h8c3a, 16'h8c7a, 16'h8cba, 16'h8cfa, 16'h8dfa, 16'h8e3a, 16'h8e7a,
            16'h8eba, 16'h8efa, 16'h8ffa,
            16'h903a, 16'h907a, 16'h90ba, 16'h90fa, 16'h91fa, 16'h923a, 16'h927a,
            16'h92ba, 16'h92fa, 16'h93fa,
            16'h943a, 16'h947a, 16'h94ba, 16'h94fa, 16'h95fa, 16'h963a, 16'h967a,
            16'h96ba, 16'h96fa, 16'h97fa,
            16'h983a, 16'h987a, 16'h98ba, 16'h98fa, 16'h99fa, 16'h9a3a, 16'h9a7a,
            16'h9aba, 16'h9afa, 16'h9bfa,
            16'h9c3a, 16'h9c7a, 16'h9cba, 16'h9cfa, 16'h9dfa, 16'h9e3a, 16'h9e7a,
            16'h9eba, 16'h9efa, 16'h9ffa,
            16'hb03a, 16'hb07a, 16'hb0ba, 16'hb0fa, 16'hb1fa, 16'hb23a, 16'hb27a,
            16'hb2ba, 16'hb2fa, 16'hb3fa,
            16'hb43a, 16'hb47a, 16'hb4ba, 16'hb4fa, 16'hb5fa, 16'hb63a, 16'hb67a,
            16'hb6ba, 16'hb6fa, 16'hb7fa,
            16'hb83a, 16'hb87a, 16'hb8ba, 16'hb8fa, 16'hb9fa, 16'hba3a, 16'hba7a,
            16'hbaba, 16'hbafa, 16'hbbfa,
            16'hbc3a, 16'hbc7a, 16'hbcba, 16'hbcfa, 16'hbdfa, 16'hbe3a, 16'hbe7a,
            16'hbeba, 16'hbefa, 16'hbffa,
            16'hc03a, 16'hc07a, 16'hc0ba, 16'hc0fa, 16'hc1fa, 16'hc23a, 16'hc27a,
            16'hc2ba, 16'hc2fa, 16'hc3fa,
            16'hc43a, 16'hc47a, 16'hc4ba, 16'hc4fa, 16'hc5fa, 16'hc63a, 16'hc67a,
            16'hc6ba, 16'hc6fa, 16'hc7fa,
            16'hc83a, 16'hc87a, 16'hc8ba, 16'hc8fa, 16'hc9fa, 16'hca3a, 16'hca7a,
            16'hcaba, 16'hcafa, 16'hcbfa,
            16'hcc3a, 16'hcc7a, 16'hccba, 16'hccfa, 16'hcdfa, 16'hce3a, 16'hce7a,
            16'hceba, 16'hcefa, 16'hcffa,
            16'hd03a, 16'hd07a, 16'hd0ba, 16'hd0fa, 16'hd1fa, 16'hd23a, 16'hd27a,
            16'hd2ba, 16'hd2fa, 16'hd3fa,
            16'hd43a, 16'hd47a, 16'hd4ba, 16'hd4fa, 16'hd5fa, 16'hd63a, 16'hd67a,
            16'hd6ba, 16'hd6fa, 16'hd7fa,
            16'hd83a, 16'hd87a, 16'hd8ba, 16'hd8fa, 16'hd9fa, 16'hda3a, 16'hda7a,
            16'hdaba, 16'hdafa, 16'hdbfa,
            16'hdc3a, 16'hdc7a, 16'hdcba, 16'hdcfa, 16'hddfa, 16'hde3a, 16'hde7a,
            16'hdeba, 16'hdefa, 16'hdffa: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    logic [15:0] flipped;

    // Flip bits 7 and 14 by pattern of the incoming word
    always_comb begin
        flipped = i_word;
        if ((i_word & 16'hf080) == 16'h8000) flipped = flipped ^ 16'h0080;
        if ((i_word & 16'hf080) == 16'hc080) flipped = flipped ^ 16'h0080;
        if ((i_word & 16'hb080) == 16'h8000) flipped = flipped ^ 16'h4000;
        if ((i_word & 16'hb100) == 16'h0000) flipped = flipped ^ 16'h4000;
    end

    // Replace masked opcodes with all ones
    always_comb begin
        o_word = flipped;
        if (is_pcrel(flipped)) begin
            o_word = MASKED;
        end else if (i_extra_mask_mode) begin
            if ((flipped & 16'hff80) == 16'h4e80) o_word = MASKED;
            if ((flipped & 16'hf0f8) == 16'h50c8) o_word = MASKED;
            if ((flipped & 16'hf000) == 16'h6000) o_word = MASKED;
        end
    end

endmodule
`default_nettype wire

FILE: sv/keyed_opcode_word_decryptor.sv
// Channel   | Handshake             | Payload
// ----------+-----------------------+-------------------------------------------------
// request   | start, busy           | i_encrypted_word, i_main_key, i_extra_mask_mode
// result    | o_valid (one cycle)   | o_decoded_word
// config    | APB psel/penable      | paddr, pwdata, prdata (keys at 0x0, 0x4, 0x8)
//
// One request per cycle; busy stays low.
// A result passes from the input register through the decode logic
// into the result register.
// Synchronous active-low reset clears the valid flags and the three keys.
// The receiver cannot stall; each result strobe lasts exactly one cycle.
`default_nettype none
module keyed_opcode_word_decryptor
    import kow_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [15:0] i_encrypted_word,
    input  wire logic [7:0]  i_main_key,
    input  wire logic        i_extra_mask_mode,
    output logic             o_valid,
    output logic      [15:0] o_decoded_word,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    t_gkeys      r_gkeys;
    logic        r_in_valid;
    logic [15:0] r_in_word;
    logic [7:0]  r_in_key;
    logic        r_in_more;
    logic        r_out_valid;
    logic [15:0] r_out_word;
    logic [15:0] round_word;
    logic [15:0] final_word;
    logic        cfg_wr;
    t_reg_idx    cfg_idx;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    // Write key registers; drop writes beyond the last register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gkeys <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_GKEY_ONE:   r_gkeys.one   <= pwdata[7:0];
                REG_GKEY_TWO:   r_gkeys.two   <= pwdata[7:0];
                REG_GKEY_THREE: r_gkeys.three <= pwdata[7:0];
                REG_UNUSED:     ;
                default:        ;
            endcase
        end
    end

    // Read back key registers
    always_comb begin
        unique case (cfg_idx)
            REG_GKEY_ONE:   prdata = {24'd0, r_gkeys.one};
            REG_GKEY_TWO:   prdata = {24'd0, r_gkeys.two};
            REG_GKEY_THREE: prdata = {24'd0, r_gkeys.three};
            default:        prdata = '0;
        endcase
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in_word <= i_encrypted_word;
            r_in_key  <= i_main_key;
            r_in_more <= i_extra_mask_mode;
        end
    end

    kow_rounds u_rounds (
        .i_word     (r_in_word),
        .i_main_key (r_in_key),
        .i_gkeys    (r_gkeys),
        .o_word     (round_word)
    );

    kow_mask u_mask (
        .i_word            (round_word),
        .i_extra_mask_mode (r_in_more),
        .o_word            (final_word)
    );

    // Register the result and its valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_out_word <= final_word;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_decoded_word = r_out_word;

    // Every result follows a request that passed the input and result registers
    a_result_follows_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 2))
        else $error("result without a request two cycles earlier");

    // In mask mode no 6xxx opcode leaves the block
    a_mask_mode_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_extra_mask_mode, 2)) |-> (o_decoded_word[15:12] != 4'h6))
        else $error("6xxx opcode passed in mask mode");

    // Outside reset, keys change only on a configuration write
    a_keys_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(cfg_wr)) |-> $stable(r_gkeys))
        else $error("global key changed without a write");

endmodule
`default_nettype wire
